/* sv/smacp_pkg.sv */
// Shared constants, types and helpers of the SMA crossover position tracker.
`default_nettype none
package smacp_pkg;

   localparam int WINDOW_MAX = 256;
   localparam int WIN_AW     = $clog2(WINDOW_MAX);
   localparam int CNT_W      = WIN_AW + 1;
   localparam int LEN_W      = 9;
   localparam int PRICE_W    = 32;
   localparam int TIME_W     = 63;
   localparam int FRAC_BITS  = 16;
   localparam int SUM_W      = PRICE_W + WIN_AW;
   localparam int PROD_W     = SUM_W + LEN_W;
   localparam int PNL_W      = 48;
   localparam int DD_W       = 47;
   // dividend: price * 100 (7 bits) shifted by the fraction, plus one bit for rounding
   localparam int DIVD_W     = PRICE_W + 7 + FRAC_BITS + 1;
   localparam int DCNT_W     = $clog2(DIVD_W);

   localparam logic [PNL_W-1:0] PNL_MAX = {1'b0, {(PNL_W-1){1'b1}}};
   localparam logic [PNL_W-1:0] PNL_MIN = {1'b1, {(PNL_W-1){1'b0}}};
   localparam logic [DD_W-1:0]  DD_MAX  = {DD_W{1'b1}};
   // one hundred percent in the quotient's fixed-point format
   localparam logic [DIVD_W-1:0] PCT_HUNDRED = DIVD_W'(100) << FRAC_BITS;

   typedef enum logic {
      CSR_SLOW_LEN = 1'b0,
      CSR_FAST_LEN = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_DECIDE,
      ST_DIV,
      ST_BOOK_TOTAL,
      ST_BOOK_PEAK,
      ST_BOOK_DD,
      ST_OUT
   } state_type;

   typedef enum logic {
      WS_IDLE,
      WS_SWEEP
   } win_state_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_RUN,
      DS_FINAL
   } div_state_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] fill;
      logic [SUM_W-1:0] fast_sum;
      logic [SUM_W-1:0] slow_sum;
   } win_res_type;

   typedef struct packed {
      logic               done;
      logic [PNL_W-1:0]   pnl;
   } div_res_type;

   // clamp a window register to 1 .. WINDOW_MAX
   function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (int'(v) > WINDOW_MAX) begin
         r = CNT_W'(WINDOW_MAX);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/smacp_if.sv */
// Request and response channel interfaces of the SMA crossover position tracker.
`default_nettype none
interface smacp_req_if;
   logic                                valid;
   logic                                ready;
   logic [smacp_pkg::PRICE_W-1:0]       close_now;
   logic [smacp_pkg::PRICE_W-1:0]       open_next;
   logic [smacp_pkg::TIME_W-1:0]        time_next;
   modport source (output valid, close_now, open_next, time_next, input ready);
   modport sink   (input valid, close_now, open_next, time_next, output ready);
endinterface

interface smacp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [1:0]                   position;
   logic                                trade_done;
   logic                                trade_side;
   logic [smacp_pkg::TIME_W-1:0]        trade_entry_time;
   logic [smacp_pkg::TIME_W-1:0]        trade_exit_time;
   logic [smacp_pkg::PRICE_W-1:0]       trade_entry_price;
   logic [smacp_pkg::PRICE_W-1:0]       trade_exit_price;
   logic signed [smacp_pkg::PNL_W-1:0]  total_pnl;
   logic [smacp_pkg::DD_W-1:0]          max_drawdown;
   modport source (output valid, position, trade_done, trade_side, trade_entry_time,
                   trade_exit_time, trade_entry_price, trade_exit_price, total_pnl,
                   max_drawdown, input ready);
   modport sink   (input valid, position, trade_done, trade_side, trade_entry_time,
                   trade_exit_time, trade_entry_price, trade_exit_price, total_pnl,
                   max_drawdown, output ready);
endinterface
`default_nettype wire

/* sv/smacp_window.sv */
// Close-price ring buffer with a serial sweep that sums the fast and slow windows.
`default_nettype none
module smacp_window (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [smacp_pkg::PRICE_W-1:0]  close,
   input  wire logic [smacp_pkg::CNT_W-1:0]    slow_len,
   input  wire logic [smacp_pkg::CNT_W-1:0]    fast_len,
   output smacp_pkg::win_res_type              res
);

   logic [smacp_pkg::PRICE_W-1:0] mem [smacp_pkg::WINDOW_MAX];

   smacp_pkg::win_state_type      state_ff;
   logic [smacp_pkg::WIN_AW-1:0]  wp_ff;
   logic [smacp_pkg::CNT_W-1:0]   fill_ff;
   logic [smacp_pkg::CNT_W-1:0]   k_ff;
   logic                          rd_vld_ff;
   logic                          in_slow_ff;
   logic                          in_fast_ff;
   logic                          done_ff;
   logic [smacp_pkg::PRICE_W-1:0] rd_data_ff;
   logic [smacp_pkg::SUM_W-1:0]   fast_sum_ff;
   logic [smacp_pkg::SUM_W-1:0]   slow_sum_ff;

   logic [smacp_pkg::CNT_W-1:0]   cnt_slow;
   logic [smacp_pkg::CNT_W-1:0]   cnt_fast;
   logic [smacp_pkg::CNT_W-1:0]   cnt_max;
   logic [smacp_pkg::CNT_W-1:0]   wp_ext;
   logic [smacp_pkg::CNT_W-1:0]   addr_ext;
   logic [smacp_pkg::WIN_AW-1:0]  rd_addr;
   logic                          wr_en;
   logic                          rd_en;

   // clip window lengths to the closes seen so far
   always_comb begin
      cnt_slow = (fill_ff < slow_len) ? fill_ff : slow_len;
      cnt_fast = (fill_ff < fast_len) ? fill_ff : fast_len;
      cnt_max  = (cnt_slow > cnt_fast) ? cnt_slow : cnt_fast;
      wp_ext   = smacp_pkg::CNT_W'(wp_ff);
      if (wp_ext > k_ff) begin
         addr_ext = wp_ext - smacp_pkg::CNT_W'(1) - k_ff;
      end else begin
         addr_ext = wp_ext + smacp_pkg::CNT_W'(smacp_pkg::WINDOW_MAX - 1) - k_ff;
      end
      rd_addr = addr_ext[smacp_pkg::WIN_AW-1:0];
      wr_en   = (state_ff == smacp_pkg::WS_IDLE) && start;
      rd_en   = (state_ff == smacp_pkg::WS_SWEEP) && (k_ff < cnt_max);
   end

   // ring buffer storage, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= close;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // sweep control and accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= smacp_pkg::WS_IDLE;
         wp_ff     <= '0;
         fill_ff   <= '0;
         k_ff      <= '0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            smacp_pkg::WS_IDLE: begin
               if (start) begin
                  wp_ff <= (int'(wp_ff) == smacp_pkg::WINDOW_MAX - 1) ? '0 :
                           wp_ff + smacp_pkg::WIN_AW'(1);
                  if (int'(fill_ff) < smacp_pkg::WINDOW_MAX) begin
                     fill_ff <= fill_ff + smacp_pkg::CNT_W'(1);
                  end
                  k_ff     <= '0;
                  state_ff <= smacp_pkg::WS_SWEEP;
               end
            end
            smacp_pkg::WS_SWEEP: begin
               rd_vld_ff <= rd_en;
               if (rd_en) begin
                  k_ff <= k_ff + smacp_pkg::CNT_W'(1);
               end else if (!rd_vld_ff) begin
                  done_ff  <= 1'b1;
                  state_ff <= smacp_pkg::WS_IDLE;
               end
            end
            default: begin
               state_ff <= smacp_pkg::WS_IDLE;
            end
         endcase
      end
   end

   // window membership flags and running sums
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fast_sum_ff <= '0;
         slow_sum_ff <= '0;
      end else begin
         if (rd_vld_ff && in_slow_ff) begin
            slow_sum_ff <= slow_sum_ff + smacp_pkg::SUM_W'(rd_data_ff);
         end
         if (rd_vld_ff && in_fast_ff) begin
            fast_sum_ff <= fast_sum_ff + smacp_pkg::SUM_W'(rd_data_ff);
         end
      end
      if (rd_en) begin
         in_slow_ff <= k_ff < cnt_slow;
         in_fast_ff <= k_ff < cnt_fast;
      end
   end

   assign res.done     = done_ff;
   assign res.fill     = fill_ff;
   assign res.fast_sum = fast_sum_ff;
   assign res.slow_sum = slow_sum_ff;

endmodule
`default_nettype wire

/* sv/smacp_divider.sv */
// Bit-serial restoring divider for the trade profit percentage.
`default_nettype none
module smacp_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [smacp_pkg::PRICE_W-1:0]  num,
   input  wire logic [smacp_pkg::PRICE_W-1:0]  den,
   output smacp_pkg::div_res_type              res
);

   smacp_pkg::div_state_type        state_ff;
   logic [smacp_pkg::DCNT_W-1:0]    cnt_ff;
   logic [smacp_pkg::DIVD_W-1:0]    divd_ff;
   logic [smacp_pkg::PRICE_W-1:0]   rem_ff;
   logic [smacp_pkg::PRICE_W-1:0]   den_ff;
   logic [smacp_pkg::PNL_W-1:0]     pnl_ff;
   logic                            done_ff;

   logic [smacp_pkg::DIVD_W-1:0]    num_ext;
   logic [smacp_pkg::DIVD_W-1:0]    dividend;
   logic [smacp_pkg::PRICE_W:0]     rem_sh;
   logic [smacp_pkg::PRICE_W:0]     rem_sub;
   logic                            q_bit;
   logic [smacp_pkg::DIVD_W-1:0]    q_diff;

   always_comb begin
      // num * 100 as shifts, then scale and add half the divisor for rounding
      num_ext  = smacp_pkg::DIVD_W'(num);
      dividend = (((num_ext << 6) + (num_ext << 5) + (num_ext << 2)) << smacp_pkg::FRAC_BITS)
                 + smacp_pkg::DIVD_W'(den >> 1);
      rem_sh   = {rem_ff, divd_ff[smacp_pkg::DIVD_W-1]};
      rem_sub  = rem_sh - {1'b0, den_ff};
      q_bit    = rem_sh >= {1'b0, den_ff};
      q_diff   = divd_ff - smacp_pkg::PCT_HUNDRED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smacp_pkg::DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            smacp_pkg::DS_IDLE: begin
               if (start) begin
                  if (den == '0) begin
                     pnl_ff  <= smacp_pkg::PNL_MAX;
                     done_ff <= 1'b1;
                  end else begin
                     state_ff <= smacp_pkg::DS_RUN;
                  end
               end
            end
            smacp_pkg::DS_RUN: begin
               if (int'(cnt_ff) == smacp_pkg::DIVD_W - 1) begin
                  state_ff <= smacp_pkg::DS_FINAL;
               end
            end
            smacp_pkg::DS_FINAL: begin
               // shift back by 100 percent, saturate large gains
               if (divd_ff >= smacp_pkg::PCT_HUNDRED &&
                   q_diff > smacp_pkg::DIVD_W'(smacp_pkg::PNL_MAX)) begin
                  pnl_ff <= smacp_pkg::PNL_MAX;
               end else begin
                  pnl_ff <= q_diff[smacp_pkg::PNL_W-1:0];
               end
               done_ff  <= 1'b1;
               state_ff <= smacp_pkg::DS_IDLE;
            end
            default: begin
               state_ff <= smacp_pkg::DS_IDLE;
            end
         endcase
      end
   end

   // one quotient bit per cycle, quotient shifts into the dividend register
   always_ff @(posedge clock) begin
      if (state_ff == smacp_pkg::DS_IDLE && start) begin
         divd_ff <= dividend;
         rem_ff  <= '0;
         den_ff  <= den;
         cnt_ff  <= '0;
      end else if (state_ff == smacp_pkg::DS_RUN) begin
         rem_ff  <= q_bit ? rem_sub[smacp_pkg::PRICE_W-1:0] : rem_sh[smacp_pkg::PRICE_W-1:0];
         divd_ff <= {divd_ff[smacp_pkg::DIVD_W-2:0], q_bit};
         cnt_ff  <= cnt_ff + smacp_pkg::DCNT_W'(1);
      end
   end

   assign res.done = done_ff;
   assign res.pnl  = pnl_ff;

endmodule
`default_nettype wire

/* sv/sma_crossover_position_tracker.sv */
// Top level of the SMA crossover position tracker.
//
// Usage: each request transaction carries one candle: close_now, plus the next
// candle's open_next and time_next. Each request yields exactly one response
// transaction with the position after that candle, the trade it closed (all
// trade fields zero if none), the accumulated profit percent and the max
// drawdown. Window lengths are to be written on the csr_ port only while idle;
// the block itself does not enforce this. Throughput: one candle at a time.
// The sweep reads n closes, one close per cycle, where n is the larger of the
// two clipped window lengths (1 to 256), as the ring buffer has one read port.
// A candle that closes a trade adds the bit-serial profit division (one
// quotient bit per cycle over 56 bits) and booking; a zero divisor skips the
// division. A new request is taken once the previous result sits in the output
// register; if the receiver stalls, the result holds there and the next
// candle is processed but waits to load until the output register frees.
// Reset: synchronous; clears position, profit totals and pointers,
// and sets slow_len to 20 and fast_len to 5. The buffer needs no clearing.
`default_nettype none
module sma_crossover_position_tracker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire smacp_pkg::csr_index_type       csr_index,
   input  wire logic [smacp_pkg::LEN_W-1:0]    csr_wdata,
   smacp_req_if.sink                           req_chan,
   smacp_rsp_if.source                         rsp_chan
);

   smacp_pkg::state_type               state_ff;
   smacp_pkg::state_type               state_in;
   logic [smacp_pkg::LEN_W-1:0]        slow_len_ff;
   logic [smacp_pkg::LEN_W-1:0]        fast_len_ff;
   logic [smacp_pkg::PRICE_W-1:0]      close_ff;
   logic [smacp_pkg::PRICE_W-1:0]      open_ff;
   logic [smacp_pkg::TIME_W-1:0]       time_ff;
   logic signed [1:0]                  held_ff;
   logic [smacp_pkg::PRICE_W-1:0]      entry_price_ff;
   logic [smacp_pkg::TIME_W-1:0]       entry_time_ff;
   logic signed [smacp_pkg::PNL_W-1:0] total_ff;
   logic signed [smacp_pkg::PNL_W-1:0] peak_ff;
   logic [smacp_pkg::DD_W-1:0]         dd_ff;
   logic [smacp_pkg::PROD_W-1:0]       lhs_ff;
   logic [smacp_pkg::PROD_W-1:0]       rhs_ff;
   logic signed [1:0]                  pos_ff;
   logic                               tr_done_ff;
   logic                               tr_side_ff;
   logic [smacp_pkg::TIME_W-1:0]       tr_et_ff;
   logic [smacp_pkg::TIME_W-1:0]       tr_xt_ff;
   logic [smacp_pkg::PRICE_W-1:0]      tr_ep_ff;
   logic [smacp_pkg::PRICE_W-1:0]      tr_xp_ff;
   logic [smacp_pkg::PRICE_W-1:0]      div_num_ff;
   logic [smacp_pkg::PRICE_W-1:0]      div_den_ff;
   logic                               rsp_valid_ff;
   logic                               sum_go_ff;

   logic [smacp_pkg::CNT_W-1:0]        sl;
   logic [smacp_pkg::CNT_W-1:0]        fl;
   logic                               win_start;
   logic                               div_start;
   logic                               rsp_load;
   logic                               full;
   logic signed [1:0]                  want;
   logic                               trade;
   logic signed [smacp_pkg::PNL_W:0]   sum_ext;
   logic [smacp_pkg::PNL_W:0]          dd_ext;
   smacp_pkg::win_res_type             win_res;
   smacp_pkg::div_res_type             div_res;

   smacp_window u_window (
      .clock    (clock),
      .reset    (reset),
      .start    (win_start),
      .close    (close_ff),
      .slow_len (sl),
      .fast_len (fl),
      .res      (win_res)
   );

   smacp_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .res   (div_res)
   );

   // decode lengths, crossover decision and saturating sums
   always_comb begin
      sl   = smacp_pkg::eff_len(slow_len_ff);
      fl   = smacp_pkg::eff_len(fast_len_ff);
      full = win_res.fill >= sl;
      want = 2'sd0;
      if (lhs_ff > rhs_ff && held_ff <= 2'sd0) begin
         want = 2'sd1;
      end else if (lhs_ff < rhs_ff && held_ff >= 2'sd0) begin
         want = -2'sd1;
      end
      trade   = full && (want != 2'sd0) && (held_ff != 2'sd0);
      sum_ext = {total_ff[smacp_pkg::PNL_W-1], total_ff}
                + {div_res.pnl[smacp_pkg::PNL_W-1], div_res.pnl};
      dd_ext  = {peak_ff[smacp_pkg::PNL_W-1], peak_ff}
                - {total_ff[smacp_pkg::PNL_W-1], total_ff};
   end

   // next state and handshake controls
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         smacp_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = smacp_pkg::ST_SUM;
            end
         end
         smacp_pkg::ST_SUM: begin
            if (!win_start && win_res.done) begin
               state_in = smacp_pkg::ST_MUL;
            end
         end
         smacp_pkg::ST_MUL: begin
            state_in = smacp_pkg::ST_DECIDE;
         end
         smacp_pkg::ST_DECIDE: begin
            state_in = trade ? smacp_pkg::ST_DIV : smacp_pkg::ST_OUT;
         end
         smacp_pkg::ST_DIV: begin
            if (div_res.done) begin
               state_in = smacp_pkg::ST_BOOK_TOTAL;
            end
         end
         smacp_pkg::ST_BOOK_TOTAL: begin
            state_in = smacp_pkg::ST_BOOK_PEAK;
         end
         smacp_pkg::ST_BOOK_PEAK: begin
            state_in = smacp_pkg::ST_BOOK_DD;
         end
         smacp_pkg::ST_BOOK_DD: begin
            state_in = smacp_pkg::ST_OUT;
         end
         smacp_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = smacp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smacp_pkg::ST_IDLE;
         end
      endcase
      if (state_ff == smacp_pkg::ST_DECIDE && trade) begin
         div_start = 1'b1;
      end
   end

   // start the sweep in the cycle after the candle is latched
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_go_ff <= 1'b0;
      end else begin
         sum_go_ff <= (state_ff == smacp_pkg::ST_IDLE) && req_chan.valid;
      end
   end
   assign win_start = sum_go_ff;

   // state register, configuration and position state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= smacp_pkg::ST_IDLE;
         slow_len_ff    <= smacp_pkg::LEN_W'(20);
         fast_len_ff    <= smacp_pkg::LEN_W'(5);
         held_ff        <= 2'sd0;
         entry_price_ff <= '0;
         entry_time_ff  <= '0;
         total_ff       <= '0;
         peak_ff        <= '0;
         dd_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               smacp_pkg::CSR_SLOW_LEN: slow_len_ff <= csr_wdata;
               smacp_pkg::CSR_FAST_LEN: fast_len_ff <= csr_wdata;
               default:                 slow_len_ff <= slow_len_ff;
            endcase
         end
         if (state_ff == smacp_pkg::ST_DECIDE && full && want != 2'sd0) begin
            held_ff        <= want;
            entry_price_ff <= open_ff;
            entry_time_ff  <= time_ff;
         end
         // saturate the running profit total
         if (state_ff == smacp_pkg::ST_BOOK_TOTAL) begin
            if (sum_ext[smacp_pkg::PNL_W] != sum_ext[smacp_pkg::PNL_W-1]) begin
               total_ff <= sum_ext[smacp_pkg::PNL_W] ? smacp_pkg::PNL_MIN : smacp_pkg::PNL_MAX;
            end else begin
               total_ff <= sum_ext[smacp_pkg::PNL_W-1:0];
            end
         end
         if (state_ff == smacp_pkg::ST_BOOK_PEAK && total_ff > peak_ff) begin
            peak_ff <= total_ff;
         end
         // track the largest drawdown, saturated
         if (state_ff == smacp_pkg::ST_BOOK_DD) begin
            if (dd_ext > smacp_pkg::DD_MAX) begin
               dd_ff <= smacp_pkg::DD_MAX;
            end else if (dd_ext[smacp_pkg::DD_W-1:0] > dd_ff) begin
               dd_ff <= dd_ext[smacp_pkg::DD_W-1:0];
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture the candle, cross-multiply and stage the result
   always_ff @(posedge clock) begin
      if (state_ff == smacp_pkg::ST_IDLE && req_chan.valid) begin
         close_ff <= req_chan.close_now;
         open_ff  <= req_chan.open_next;
         time_ff  <= req_chan.time_next;
      end
      if (state_ff == smacp_pkg::ST_MUL) begin
         lhs_ff <= win_res.fast_sum * smacp_pkg::PROD_W'(sl);
         rhs_ff <= win_res.slow_sum * smacp_pkg::PROD_W'(fl);
      end
      if (state_ff == smacp_pkg::ST_DECIDE) begin
         pos_ff     <= !full ? 2'sd0 : ((want != 2'sd0) ? want : held_ff);
         tr_done_ff <= trade;
         tr_side_ff <= trade && (held_ff < 2'sd0);
         tr_et_ff   <= trade ? entry_time_ff : '0;
         tr_xt_ff   <= trade ? time_ff : '0;
         tr_ep_ff   <= trade ? entry_price_ff : '0;
         tr_xp_ff   <= trade ? open_ff : '0;
      end
      if (state_ff == smacp_pkg::ST_MUL) begin
         div_num_ff <= (held_ff < 2'sd0) ? entry_price_ff : close_ff;
         div_den_ff <= (held_ff < 2'sd0) ? close_ff : entry_price_ff;
      end
      if (rsp_load) begin
         rsp_chan.position          <= pos_ff;
         rsp_chan.trade_done        <= tr_done_ff;
         rsp_chan.trade_side        <= tr_side_ff;
         rsp_chan.trade_entry_time  <= tr_et_ff;
         rsp_chan.trade_exit_time   <= tr_xt_ff;
         rsp_chan.trade_entry_price <= tr_ep_ff;
         rsp_chan.trade_exit_price  <= tr_xp_ff;
         rsp_chan.total_pnl         <= total_ff;
         rsp_chan.max_drawdown      <= dd_ff;
      end
   end

   assign req_chan.ready = (state_ff == smacp_pkg::ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* sv/smacp_checker.sv */
// Port-level assertions for the SMA crossover position tracker, bound to the top level.
`default_nettype none
module smacp_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [1:0]                    rsp_position,
   input  wire logic                          rsp_trade_done,
   input  wire logic                          rsp_trade_side,
   input  wire logic [smacp_pkg::PRICE_W-1:0] rsp_trade_entry_price
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a closed trade always flips into the opposite side
   a_trade_flip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trade_done |->
         ((rsp_trade_side && rsp_position == 2'b01) ||
          (!rsp_trade_side && rsp_position == 2'b11)))
      else $error("closed trade without a flip");

   // no trade fields without a closed trade
   a_no_trade: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_trade_done |-> rsp_trade_entry_price == '0 && !rsp_trade_side)
      else $error("trade fields set with no trade");

   // position code never shows the unused pattern
   a_pos_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position != 2'b10)
      else $error("illegal position code");

endmodule

bind sma_crossover_position_tracker smacp_checker u_smacp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_position          (rsp_chan.position),
   .rsp_trade_done        (rsp_chan.trade_done),
   .rsp_trade_side        (rsp_chan.trade_side),
   .rsp_trade_entry_price (rsp_chan.trade_entry_price)
);
`default_nettype wire
